FILE: sv/pbve_pkg.sv
// Package for the posting block varbyte encoder.
// Shared widths, varbyte constants and the encoded-value struct; no dependencies.
package pbve_pkg;

   localparam int unsigned ID_W      = 32;
   localparam int unsigned FREQ_W    = 32;
   localparam int unsigned CODE_W    = 40;
   localparam int unsigned LEN_W     = 3;
   localparam int unsigned SUM_W     = 13;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned VB_GROUPS = 5;

   localparam logic [6:0] VB_MASK  = 7'h7F;
   localparam logic [7:0] VB_MORE  = 8'h80;
   localparam int unsigned VB_SHIFT = 7;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 176;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } vb_code_type;

endpackage

FILE: sv/pbve_varbyte.sv
// Varbyte encoder for one 32-bit value: five 7-bit groups, low group first.
// Depends on pbve_pkg.
module pbve_varbyte (
   input  logic [31:0]         value,
   output pbve_pkg::vb_code_type enc
);

   logic [31:0]                  rest [pbve_pkg::VB_GROUPS+1];
   logic [pbve_pkg::CODE_W-1:0]  code;
   logic [pbve_pkg::LEN_W-1:0]   len;

   // Byte i is zero on its own when nothing remains from group i up, so no
   // per-byte length masking is needed.
   always_comb begin
      code = '0;
      len  = '0;
      for (int i = 0; i <= pbve_pkg::VB_GROUPS; i++) begin
         rest[i] = value >> (pbve_pkg::VB_SHIFT * i);
      end
      for (int i = 0; i < pbve_pkg::VB_GROUPS; i++) begin
         code[8*i +: 8] = ((rest[i+1] != '0) ? pbve_pkg::VB_MORE : 8'h00)
                        | {1'b0, rest[i][6:0] & pbve_pkg::VB_MASK};
         if (rest[i] != '0) begin
            len = pbve_pkg::LEN_W'(i + 1);
         end
      end
   end

   assign enc.code = code;
   assign enc.len  = len;

endmodule

FILE: sv/posting_block_varbyte_encoder.sv
// Top level of the posting block varbyte encoder.
// Depends on pbve_pkg and pbve_varbyte.
//
// Takes one posting per transaction on req_*: doc_id and freq in req_tdata,
// the end-of-list mark on req_tlast. Each posting gives exactly one result on
// rsp_*: the varbyte codes of the docid delta and of the frequency, the list
// posting count, and, when the posting closes a block (rsp_tlast), the
// block's last id and its docid/freq byte totals. rsp_tuser flags an id that
// went backwards (the delta wrapped modulo 2^32).
// A block closes after POSTINGS_PER_BLK postings or at the end of a list;
// the delta base returns to zero at each block start.
// Between req acceptance and rsp_tvalid lie an input register and a result
// register, with the delta, encoding and running sums between them. One
// posting per cycle is sustained while the receiver keeps rsp_tready high;
// the per-block state is updated in the same cycle the result register loads,
// so consecutive postings never wait on each other.
// When the receiver stalls, both stages hold and req_tready falls once they
// are full. Synchronous reset empties both stages and clears the previous id,
// block fill, byte sums and list count.
module posting_block_varbyte_encoder #(
   parameter int unsigned POSTINGS_PER_BLK = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // doc_id[31:0], freq[63:32]
   input  logic         req_tlast,   // list_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata,   // delta_code[39:0], delta_len[42:40],
                                     // freq_code[82:43], freq_len[85:83],
                                     // block_last_id[117:86],
                                     // block_id_bytes[130:118],
                                     // block_freq_bytes[143:131],
                                     // posting_count[175:144]
   output logic         rsp_tlast,   // block_done
   output logic         rsp_tuser    // out_of_order
);

   localparam int unsigned FILL_W = $clog2(POSTINGS_PER_BLK + 1);

   // input stage
   logic                          s1_valid_ff;
   logic [pbve_pkg::ID_W-1:0]     s1_id_ff;
   logic [pbve_pkg::FREQ_W-1:0]   s1_freq_ff;
   logic                          s1_last_ff;

   // block state
   logic [pbve_pkg::ID_W-1:0]     prev_id_ff,  prev_id_in;
   logic [FILL_W-1:0]             block_fill_ff, block_fill_in;
   logic [pbve_pkg::SUM_W-1:0]    id_sum_ff,   id_sum_in;
   logic [pbve_pkg::SUM_W-1:0]    freq_sum_ff, freq_sum_in;
   logic [pbve_pkg::COUNT_W-1:0]  list_count_ff, list_count_in;

   // result stage
   logic                          rsp_valid_ff;
   logic [pbve_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_user_ff, rsp_user_in;

   logic                          out_ready;
   logic                          s1_advance;
   logic [pbve_pkg::ID_W-1:0]     delta;
   pbve_pkg::vb_code_type         delta_enc;
   pbve_pkg::vb_code_type         freq_enc;
   logic [pbve_pkg::SUM_W-1:0]    id_sum_next;
   logic [pbve_pkg::SUM_W-1:0]    freq_sum_next;
   logic [FILL_W-1:0]             fill_next;
   logic [pbve_pkg::COUNT_W-1:0]  count_next;
   logic                          done;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_id_ff   <= req_tdata[31:0];
         s1_freq_ff <= req_tdata[63:32];
         s1_last_ff <= req_tlast;
      end
   end

   assign delta = s1_id_ff - prev_id_ff;

   pbve_varbyte u_delta_vb (
      .value (delta),
      .enc   (delta_enc)
   );

   pbve_varbyte u_freq_vb (
      .value (s1_freq_ff),
      .enc   (freq_enc)
   );

   always_comb begin
      id_sum_next   = id_sum_ff + pbve_pkg::SUM_W'(delta_enc.len);
      freq_sum_next = freq_sum_ff + pbve_pkg::SUM_W'(freq_enc.len);
      fill_next     = block_fill_ff + FILL_W'(1);
      count_next    = list_count_ff + pbve_pkg::COUNT_W'(1);
      done          = s1_last_ff || (fill_next == FILL_W'(POSTINGS_PER_BLK));

      rsp_data_in = {count_next,
                     done ? freq_sum_next : '0,
                     done ? id_sum_next   : '0,
                     done ? s1_id_ff      : '0,
                     freq_enc.len, freq_enc.code,
                     delta_enc.len, delta_enc.code};
      rsp_last_in = done;
      rsp_user_in = s1_id_ff < prev_id_ff;

      if (done) begin
         prev_id_in    = '0;
         block_fill_in = '0;
         id_sum_in     = '0;
         freq_sum_in   = '0;
      end else begin
         prev_id_in    = s1_id_ff;
         block_fill_in = fill_next;
         id_sum_in     = id_sum_next;
         freq_sum_in   = freq_sum_next;
      end
      list_count_in = s1_last_ff ? '0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_id_ff    <= '0;
         block_fill_ff <= '0;
         id_sum_ff     <= '0;
         freq_sum_ff   <= '0;
         list_count_ff <= '0;
      end else if (s1_advance) begin
         prev_id_ff    <= prev_id_in;
         block_fill_ff <= block_fill_in;
         id_sum_ff     <= id_sum_in;
         freq_sum_ff   <= freq_sum_in;
         list_count_ff <= list_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // block fill never reaches the block size: the posting that would fill it closes it
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      block_fill_ff < FILL_W'(POSTINGS_PER_BLK))
      else $error("block fill reached block size");

   // block report fields are zero unless the transaction closes a block
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[143:86] == '0)
      else $error("block report without block close");

   // a wrapped delta is never zero, so it always has code bytes
   a_wrap_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[42:40] != '0)
      else $error("out-of-order posting with empty delta code");

   // the closing posting's bytes are included in the block total
   a_sum_incl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[130:118] >= 13'(rsp_tdata[42:40]))
      else $error("block docid byte total below last delta length");

endmodule
